FILE: hdl/apa_pkg.sv
// Shared types, constants and the host-step function of the address pool allocator.
// Depends on nothing; apa_lease_mem and address_pool_allocator import it.
package apa_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned OFFERS_PER_REQ  = 3;
  localparam logic [11:0] OFFER_LEASE     = 12'd3600;
  localparam logic [31:0] MASK_RESET      = 32'hFFFF_FF00;

  // configuration register indexes
  localparam logic REG_GATEWAY = 1'b0;
  localparam logic REG_MASK    = 1'b1;

  typedef enum logic [1:0] {
    KIND_OFFER     = 2'd0,
    KIND_ACK       = 2'd1,
    KIND_EXHAUSTED = 2'd2,
    KIND_FULL      = 2'd3
  } apa_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_EMIT,
    ST_EXH,
    ST_REPLY
  } apa_state_e;

  // next host offset: wraps inside the host part, carries across set mask bits
  function automatic logic [31:0] host_step(input logic [31:0] off, input logic [31:0] mask);
    host_step = ((off | mask) + 32'd1) & ~mask;
  endfunction

endpackage

FILE: hdl/apa_lease_mem.sv
// Lease table storage: one write port, one read port, registered read data.
// Depends on apa_pkg.
module apa_lease_mem
  import apa_pkg::*;
#(
  parameter int unsigned DEPTH  = TABLE_DEPTH_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [31:0]       wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [31:0]       rdata_o
);

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/address_pool_allocator.sv
// Address pool allocator top level: request handling, offer search, result register.
// Depends on apa_pkg and apa_lease_mem.
//
//  channel   direction  handshake               payload
//  request   in         in_valid_i / in_stall_o  request_ip_i
//  result    out        out_valid_o / out_stall_i result_kind_o, result_ip_o,
//                                                 lease_seconds_o, last_o
//  config    in         cfg_we_i                 cfg_idx_i, cfg_data_i
//
// A register request goes through the reply state, plus any wait on the result register.
// An offer request walks candidates one at a time; each candidate gets a
// gateway check and then a scan of the table entries below the lease count
// through the single memory read port (one entry per cycle), stopping early on a hit.
// The gateway is rejected in the check state alone, and an empty table is not
// scanned. Each offer is then loaded from the emit state.
// Up to three searches run per offer request. Requests are taken one at a time.
// Reset clears the lease count, cursor and gateway and sets the mask to MASK_RESET;
// the table memory itself is not cleared, only entries below the count are ever read.
// A stalled result holds the engine in its emit, exhausted or reply state until taken.
module address_pool_allocator
  import apa_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // request words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] request_ip_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [31:0] result_ip_o,
  output logic [11:0] lease_seconds_o,
  output logic        last_o
);

  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = ADDR_W + 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);
  localparam logic [1:0] LAST_OFFER = 2'(OFFERS_PER_REQ - 1);

  apa_state_e state_q, state_d;

  // architectural state
  logic [31:0]      gateway_q, gateway_d;
  logic [31:0]      mask_q, mask_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [31:0]      cursor_q, cursor_d;

  // search state
  logic [31:0]      off_q, off_d;      // candidate host offset
  logic [31:0]      start_q, start_d;  // where this search began
  logic [CNT_W-1:0] idx_q, idx_d;      // next table entry to read
  logic             rd_valid_q, rd_valid_d;
  logic [1:0]       offers_q, offers_d;

  // pending ack / full reply
  apa_kind_e   reply_kind_q, reply_kind_d;
  logic [31:0] reply_ip_q, reply_ip_d;

  // result register
  logic        out_valid_q, out_valid_d;
  apa_kind_e   out_kind_q, out_kind_d;
  logic [31:0] out_ip_q, out_ip_d;
  logic [11:0] out_lease_q, out_lease_d;
  logic        out_last_q, out_last_d;

  logic        in_fire, out_fire, slot_free, out_load;
  logic        table_full, gw_hit, hit, scan_done, step_wraps, issue;
  logic [31:0] cand, step_off, rd_data;
  logic        mem_we;

  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_q && !out_stall_i;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign table_full = (count_q == CNT_FULL);

  assign cand       = (gateway_q & mask_q) | off_q;
  assign step_off   = host_step(off_q, mask_q);
  assign step_wraps = (step_off == start_q);
  assign gw_hit     = (cand == gateway_q);
  assign hit        = rd_valid_q && (rd_data == cand);
  assign scan_done  = (idx_q == count_q) && !hit;
  assign issue      = (state_q == ST_SCAN) && !hit && (idx_q != count_q);

  assign mem_we = in_fire && (request_ip_i != 32'd0) && !table_full;

  apa_lease_mem #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (request_ip_i),
    .re_i    (issue),
    .raddr_i (idx_q[ADDR_W-1:0]),
    .rdata_o (rd_data)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (request_ip_i == 32'd0) ? ST_CHECK : ST_REPLY;
        end
      end
      ST_CHECK: begin
        if (gw_hit) begin
          state_d = step_wraps ? ST_EXH : ST_CHECK;
        end else if (count_q == '0) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_d = step_wraps ? ST_EXH : ST_CHECK;
        end else if (scan_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_d = (offers_q == LAST_OFFER) ? ST_IDLE : ST_CHECK;
        end
      end
      ST_EXH, ST_REPLY: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    gateway_d    = gateway_q;
    mask_d       = mask_q;
    count_d      = count_q;
    cursor_d     = cursor_q;
    off_d        = off_q;
    start_d      = start_q;
    idx_d        = idx_q;
    rd_valid_d   = issue;
    offers_d     = offers_q;
    reply_kind_d = reply_kind_q;
    reply_ip_d   = reply_ip_q;
    out_kind_d   = out_kind_q;
    out_ip_d     = out_ip_q;
    out_lease_d  = out_lease_q;
    out_last_d   = out_last_q;
    out_load     = 1'b0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GATEWAY: gateway_d = cfg_data_i;
        REG_MASK:    mask_d    = cfg_data_i;
        default:     ;
      endcase
    end

    if (issue) begin
      idx_d = idx_q + CNT_W'(1);
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (request_ip_i == 32'd0) begin
            off_d    = cursor_q & ~mask_q;
            start_d  = cursor_q & ~mask_q;
            offers_d = '0;
          end else if (table_full) begin
            reply_kind_d = KIND_FULL;
            reply_ip_d   = 32'd0;
          end else begin
            reply_kind_d = KIND_ACK;
            reply_ip_d   = request_ip_i;
            count_d      = count_q + CNT_W'(1);
          end
        end
      end
      ST_CHECK: begin
        idx_d = '0;
        if (gw_hit && !step_wraps) begin
          off_d = step_off;
        end
      end
      ST_SCAN: begin
        if (hit && !step_wraps) begin
          off_d = step_off;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_load    = 1'b1;
          out_kind_d  = KIND_OFFER;
          out_ip_d    = cand;
          out_lease_d = OFFER_LEASE;
          out_last_d  = (offers_q == LAST_OFFER);
          cursor_d    = step_off;
          off_d       = step_off;
          start_d     = step_off;
          offers_d    = offers_q + 2'd1;
        end
      end
      ST_EXH: begin
        if (slot_free) begin
          out_load    = 1'b1;
          out_kind_d  = KIND_EXHAUSTED;
          out_ip_d    = 32'd0;
          out_lease_d = 12'd0;
          out_last_d  = 1'b1;
        end
      end
      ST_REPLY: begin
        if (slot_free) begin
          out_load    = 1'b1;
          out_kind_d  = reply_kind_q;
          out_ip_d    = reply_ip_q;
          out_lease_d = 12'd0;
          out_last_d  = 1'b1;
        end
      end
      default: ;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gateway_q   <= 32'd0;
      mask_q      <= MASK_RESET;
      count_q     <= '0;
      cursor_q    <= 32'd0;
      idx_q       <= '0;
      rd_valid_q  <= 1'b0;
      offers_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gateway_q   <= gateway_d;
      mask_q      <= mask_d;
      count_q     <= count_d;
      cursor_q    <= cursor_d;
      idx_q       <= idx_d;
      rd_valid_q  <= rd_valid_d;
      offers_q    <= offers_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q        <= off_d;
    start_q      <= start_d;
    reply_kind_q <= reply_kind_d;
    reply_ip_q   <= reply_ip_d;
    out_kind_q   <= out_kind_d;
    out_ip_q     <= out_ip_d;
    out_lease_q  <= out_lease_d;
    out_last_q   <= out_last_d;
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = out_kind_q;
  assign result_ip_o     = out_ip_q;
  assign lease_seconds_o = out_lease_q;
  assign last_o          = out_last_q;

  // lease count never passes the table depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("lease count beyond table depth");

  // a register request always goes to the reply state next
  a_reg_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (request_ip_i != 32'd0)) |=> (state_q == ST_REPLY))
    else $error("register request did not reach reply");

  // an exhausted result leaves the cursor alone
  a_exh_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (state_q == ST_EXH)) |=> $stable(cursor_q))
    else $error("cursor moved on exhausted search");

endmodule

FILE: tb/address_pool_allocator_tb.sv
// Self-checking testbench for address_pool_allocator: offer, ack, exhausted and table-full
// replies checked word by word against an in-bench model of the lease pool.
// Depends on apa_pkg and the address_pool_allocator RTL.
module address_pool_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import apa_pkg::*;

  localparam int unsigned LEASE_DEPTH = TABLE_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  // one expected reply word
  typedef struct packed {
    apa_kind_e   kind;
    logic [31:0] ip;
    logic [11:0] lease;
    logic        last;
  } lease_reply_t;

  logic        clk_i;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_idx    = REG_GATEWAY;
  logic [31:0] cfg_data   = '0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [31:0] request_ip = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [1:0]  result_kind;
  logic [31:0] result_ip;
  logic [11:0] lease_seconds;
  logic        last;

  // stimulus bookkeeping
  logic [31:0]  req_words[$];       // request words waiting for the driver
  lease_reply_t pending_replies[$]; // predicted replies, oldest first
  int           words_queued = 0;
  int           words_taken  = 0;
  logic         req_fired    = 1'b0; // request word taken at the last rising edge
  logic         calm         = 1'b0; // no gaps and no stalls while set
  int           send_gap     = 0;
  int           stall_left   = 0;
  int           errors       = 0;
  int unsigned  cycles       = 0;

  // model of the pool: registers, lease table and search cursor
  logic [31:0] pool_gw   = '0;
  logic [31:0] pool_mask = MASK_RESET;
  logic [31:0] lease_mem[LEASE_DEPTH];
  int          lease_cnt = 0;
  logic [31:0] host_cur  = '0;

  address_pool_allocator #(
    .TABLE_DEPTH(LEASE_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .request_ip_i   (request_ip),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_kind_o  (result_kind),
    .result_ip_o    (result_ip),
    .lease_seconds_o(lease_seconds),
    .last_o         (last)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Pool model
  // ---------------------------------------------------------------------------

  // Advance a host offset by one: the mask bits are forced high so the carry
  // ripples across them, then cleared again, so the host part wraps to zero.
  function automatic logic [31:0] next_host(input logic [31:0] off);
    return ((off | pool_mask) + 32'd1) & ~pool_mask;
  endfunction

  // Gateway and every registered lease are off limits.
  function automatic logic addr_reserved(input logic [31:0] addr);
    if (addr == pool_gw) return 1'b1;
    for (int i = 0; i < lease_cnt; i++) begin
      if (lease_mem[i] == addr) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void add_reply(input apa_kind_e kind, input logic [31:0] ip,
                                    input logic [11:0] lease, input logic fin);
    lease_reply_t r;
    r.kind  = kind;
    r.ip    = ip;
    r.lease = lease;
    r.last  = fin;
    pending_replies.push_back(r);
  endfunction

  // Predict the replies to one accepted request word and update the model.
  function automatic void serve_request(input logic [31:0] req);
    logic [31:0] base, start_off, off;
    logic        found, scanning, stop;
    // nonzero word: register, no duplicate or gateway check
    if (req != '0) begin
      if (lease_cnt >= LEASE_DEPTH) begin
        add_reply(KIND_FULL, '0, '0, 1'b1);
      end else begin
        lease_mem[lease_cnt] = req;
        lease_cnt++;
        add_reply(KIND_ACK, req, '0, 1'b1);
      end
      return;
    end
    // zero word: up to three offers, each search starting at the cursor
    base = pool_gw & pool_mask;
    stop = 1'b0;
    for (int n = 0; n < OFFERS_PER_REQ && !stop; n++) begin
      start_off = host_cur & ~pool_mask;
      off       = start_off;
      found     = 1'b0;
      scanning  = 1'b1;
      while (scanning) begin
        if (!addr_reserved(base | off)) begin
          found    = 1'b1;
          scanning = 1'b0;
        end else begin
          off      = next_host(off);
          scanning = (off != start_off);
        end
      end
      if (found) begin
        add_reply(KIND_OFFER, base | off, OFFER_LEASE, n == OFFERS_PER_REQ - 1);
        host_cur = next_host(off);
      end else begin
        // full lap without a free address: cursor stays, request ends here
        add_reply(KIND_EXHAUSTED, '0, '0, 1'b1);
        stop = 1'b1;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_reply();
    lease_reply_t want;
    if (pending_replies.size() == 0) begin
      report_mismatch($sformatf("unexpected reply kind=%0d ip=%h lease=%0d last=%b",
                                result_kind, result_ip, lease_seconds, last));
      return;
    end
    want = pending_replies.pop_front();
    if (result_kind !== want.kind || result_ip !== want.ip ||
        lease_seconds !== want.lease || last !== want.last) begin
      report_mismatch($sformatf({"got kind=%0d ip=%h lease=%0d last=%b, ",
                                 "want kind=%0d ip=%h lease=%0d last=%b"},
                                result_kind, result_ip, lease_seconds, last,
                                want.kind, want.ip, want.lease, want.last));
    end
  endtask

  // Monitor: samples both channels at the rising edge. The reply check runs
  // first so a stray reply is never hidden by a prediction made at the same edge.
  always @(posedge clk_i) begin
    if (!rst_n) begin
      req_fired <= 1'b0;
    end else begin
      req_fired <= in_valid && !in_stall;
      if (out_valid && !out_stall) check_reply();
      if (in_valid && !in_stall) begin
        serve_request(request_ip);
        words_taken++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycles,
               pending_replies.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver and receiver, both on the falling edge
  // ---------------------------------------------------------------------------

  // idle length: mostly none, often short, now and then long
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // A word stays on the bus until taken; the gap picked at launch is spent
  // after it is accepted, before the next word goes out.
  always @(negedge clk_i) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_fired) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (req_words.size() != 0) begin
        in_valid   <= 1'b1;
        request_ip <= req_words.pop_front();
        send_gap = calm ? 0 : idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall runs of random length, independent of out_valid.
  always @(negedge clk_i) begin
    if (!rst_n || calm) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = idle_len();
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer helpers; words are queued at the rising edge, the driver pops
  // them at the falling edge, counters are read at the falling edge.
  // ---------------------------------------------------------------------------

  task automatic queue_word(input logic [31:0] w);
    req_words.push_back(w);
    words_queued++;
  endtask

  // Block until every queued word is taken and every reply has arrived.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (words_taken != words_queued || pending_replies.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Register write; only called with the engine idle, model follows at once.
  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    if (idx == REG_GATEWAY) pool_gw = val;
    else pool_mask = val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic new_pool(input logic [31:0] gw, input logic [31:0] mask);
    wait_idle();
    write_reg(REG_GATEWAY, gw);
    write_reg(REG_MASK, mask);
    @(posedge clk_i);
  endtask

  // Mix of discover words and registrations. Most registrations land in the
  // current pool, half of those just ahead of the cursor so searches skip.
  task automatic random_burst(input int count, input int reg_pct);
    logic [31:0] base, host;
    int unsigned r;
    for (int i = 0; i < count; i++) begin
      base = pool_gw & pool_mask;
      r    = $urandom_range(0, 99);
      if (r >= reg_pct) begin
        queue_word('0);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) host = host_cur + $urandom_range(0, 3);
        else host = $urandom;
        if (r < 85) queue_word(base | (host & ~pool_mask));
        else queue_word($urandom);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(negedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Reset pool: gateway 0 is the network address, so the first search
    // skips it; then registrations at both ends of the address range.
    queue_word(32'h0000_0000);
    queue_word(32'hFFFF_FFFF);
    queue_word(32'h0000_0001);
    queue_word(32'h0000_0000);
    queue_word(32'h0000_0007);
    queue_word(32'h0000_0008);
    queue_word(32'h0000_0000);
    queue_word(32'h8000_0000);

    // Four-address pool: network and broadcast get offered, the host part
    // wraps, gateway and duplicate registrations are simply stored, two free
    // addresses give a repeated offer, and an empty pool reports exhausted.
    new_pool(32'h0A00_0001, 32'hFFFF_FFFC);
    queue_word(32'h0000_0000);
    queue_word(32'h0A00_0001);
    queue_word(32'h0A00_0002);
    queue_word(32'h0A00_0002);
    queue_word(32'h0000_0000);
    queue_word(32'h0A00_0000);
    queue_word(32'h0A00_0003);
    queue_word(32'h0000_0000);

    // All-ones mask: the only candidate is the gateway itself.
    new_pool(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_word(32'h0000_0000);

    // Zero mask: every address is host part.
    new_pool(32'h0000_0000, 32'h0000_0000);
    queue_word(32'h0000_0000);
    queue_word(32'h0000_000C);
    queue_word(32'h0000_0000);

    // Mask with holes: the step carries across the set bits.
    new_pool(32'h5A5A_5A5A, 32'h0F0F_0F0F);
    queue_word(32'h0000_0000);
    queue_word(32'h0000_0000);

    // Random phases over different pool shapes.
    new_pool($urandom, 32'hFFFF_FF00);
    random_burst(60, 45);
    new_pool($urandom, 32'hFFFF_FFF0);
    random_burst(60, 40);
    calm = 1'b1;
    new_pool(32'hFFFF_FFFF, 32'h0000_0000);
    random_burst(60, 45);
    new_pool($urandom, $urandom | $urandom);
    calm = 1'b0;
    random_burst(60, 45);

    // Fill the lease table, then show it full to registrations while offers
    // still work from a wide pool.
    new_pool($urandom, 32'hFFFF_F000);
    repeat (LEASE_DEPTH - lease_cnt) queue_word((pool_gw & pool_mask) | ($urandom & ~pool_mask));
    queue_word(32'h0000_0000);
    queue_word($urandom | 32'h1);
    queue_word(32'hFFFF_FFFF);
    queue_word(32'h0000_0000);

    wait_idle();
    repeat (32) @(negedge clk_i);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/apa_pkg.sv
hdl/apa_lease_mem.sv
hdl/address_pool_allocator.sv
tb/address_pool_allocator_tb.sv
